### rtl/kecq_pkg.sv
// Package for the key event code queue: shared types, operation codes and
// small helper functions for code formatting.
// Depends on nothing; kecq_fifo, the top level and the testbench import it.
package kecq_pkg;

    localparam int KEY_BITS  = 7;
    localparam int CODE_BITS = 8;
    localparam int FILL_BITS = 5;
    localparam int KEY_COUNT = 128;

    typedef logic [2:0]           t_op;
    typedef logic [KEY_BITS-1:0]  t_key;
    typedef logic [CODE_BITS-1:0] t_code;
    typedef logic [FILL_BITS-1:0] t_fill;

    localparam t_op OP_KEY   = 3'd0;
    localparam t_op OP_CTRL  = 3'd1;
    localparam t_op OP_CAPS  = 3'd2;
    localparam t_op OP_DEQ   = 3'd3;
    localparam t_op OP_CLEAR = 3'd4;

    localparam t_key CAPS_KEY_RESET = 7'd98;

    // Queue commands from the decode stage to the queue controller.
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_fifo_ctl;

    // Queue status back to the decode stage.
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    // Make-or-break code: the key number with the top bit set on release.
    function automatic t_code f_edge_code(input t_key key, input logic down);
        f_edge_code = {~down, key};
    endfunction

    // Serial line form: the code inverted, then rotated left by one bit.
    function automatic t_code f_serial(input t_code c);
        t_code inv;
        inv      = ~c;
        f_serial = {inv[CODE_BITS-2:0], inv[CODE_BITS-1]};
    endfunction

endpackage

### rtl/kecq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the code queue storage.
module kecq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/kecq_fifo.sv
// Ring queue controller: head pointer, fill count, storage RAM and a
// write-to-read bypass so the head code is ready whenever a pop is decoded.
// Depends on kecq_pkg and kecq_ram.
module kecq_fifo #(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  kecq_pkg::t_fifo_ctl        i_ctl,
    input  kecq_pkg::t_code            i_wdata,
    output kecq_pkg::t_fifo_stat       o_stat,
    output kecq_pkg::t_code            o_head_code,
    output logic [$clog2(DEPTH+1)-1:0] o_count,
    output logic [$clog2(DEPTH+1)-1:0] o_next_count
);
    import kecq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;

    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [SW-1:0] slot_sum;
    logic [AW-1:0] slot;
    logic [AW-1:0] head_inc;
    logic          r_byp, n_byp;
    t_code         r_byp_data;
    t_code         ram_rdata;

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    // Tail slot is head plus count, wrapped without a divider.
    assign slot_sum = SW'(r_head) + SW'(r_count);
    assign slot     = (slot_sum >= SW'(DEPTH)) ? AW'(slot_sum - SW'(DEPTH)) : AW'(slot_sum);
    assign head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_ctl.clear) begin
            n_head  = '0;
            n_count = '0;
        end else if (i_ctl.push) begin
            n_count = r_count + 1'b1;
        end else if (i_ctl.pop) begin
            n_head  = head_inc;
            n_count = r_count - 1'b1;
        end
    end

    // The RAM reads the head that will hold after this cycle; a write to that
    // very slot in the same cycle is forwarded instead.
    assign n_byp = i_ctl.push && (slot == n_head);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_byp   <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_byp   <= n_byp;
        end
        r_byp_data <= i_wdata;
    end

    kecq_ram #(
        .WIDTH(CODE_BITS),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_ctl.push),
        .i_waddr(slot),
        .i_wdata(i_wdata),
        .i_raddr(n_head),
        .o_rdata(ram_rdata)
    );

    assign o_head_code  = r_byp ? r_byp_data : ram_rdata;
    assign o_count      = r_count;
    assign o_next_count = n_count;

endmodule

### rtl/key_event_code_queue_unit.sv
// Top level of the key event code queue: input register, operation decode
// with key map and caps lock LED, result register.
// Depends on kecq_pkg and kecq_fifo (which holds kecq_ram).
//
//  Channel   | Ports                                             | Transfer
//  ----------+---------------------------------------------------+-------------------------
//  command   | i_start, o_busy, i_op, i_key_code, i_pressed,     | i_start high, o_busy low
//            | i_control_code                                    |
//  result    | o_done, o_accepted, o_out_valid, o_out_code,      | o_done high, one cycle
//            | o_serial_code, o_caps_led, o_fill_count           |
//  config    | i_cfg_we, i_cfg_data                              | i_cfg_we high
//
// One command is taken in every cycle; o_busy never rises. The result of a
// command passes through the input register and then the decode stage, whose
// key map, LED and queue updates are a single read-modify-write that commits
// together with the result register.
// Reset is synchronous and active low: the queue empties, every key is up,
// the LED is off and the caps lock key number returns to 98.
// The receiver cannot stall, so each result is held for exactly one cycle.
module key_event_code_queue_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Command channel.
    input  logic             i_start,
    output logic             o_busy,
    input  kecq_pkg::t_op    i_op,
    input  kecq_pkg::t_code  i_key_code,
    input  logic             i_pressed,
    input  kecq_pkg::t_code  i_control_code,
    // Result channel.
    output logic             o_done,
    output logic             o_accepted,
    output logic             o_out_valid,
    output kecq_pkg::t_code  o_out_code,
    output kecq_pkg::t_code  o_serial_code,
    output logic             o_caps_led,
    output kecq_pkg::t_fill  o_fill_count,
    // Configuration: caps lock key number.
    input  logic             i_cfg_we,
    input  kecq_pkg::t_key   i_cfg_data
);
    import kecq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // Input register.
    logic  r_vld;
    t_op   r_op;
    t_code r_key_code;
    logic  r_pressed;
    t_code r_control_code;

    // Block state outside the queue.
    logic [KEY_COUNT-1:0] r_key_held, n_key_held;
    logic                 r_led, n_led;
    t_key                 r_caps_key;

    // Result register.
    logic  r_done;
    logic  r_accepted, n_accepted;
    logic  r_out_valid, n_out_valid;
    t_code r_out_code, n_out_code;
    t_code r_serial_code;
    t_fill r_fill_count;

    // Queue interface.
    t_fifo_ctl     fifo_ctl;
    t_fifo_stat    fifo_stat;
    t_code         push_code;
    t_code         head_code;
    logic [CW-1:0] count;
    logic [CW-1:0] next_count;

    t_key key;
    logic held;

    // Every cycle is open for a new command; the decode stage finishes each
    // command in one pass.
    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_start && !o_busy;
        end
        if (i_start && !o_busy) begin
            r_op           <= i_op;
            r_key_code     <= i_key_code;
            r_pressed      <= i_pressed;
            r_control_code <= i_control_code;
        end
    end

    assign key  = r_key_code[KEY_BITS-1:0];
    assign held = r_key_held[key];

    // Decode: one command against the present state. A full queue rejects
    // any enqueue and then nothing else changes either.
    always_comb begin
        fifo_ctl    = '0;
        push_code   = r_control_code;
        n_key_held  = r_key_held;
        n_led       = r_led;
        n_accepted  = 1'b0;
        n_out_valid = 1'b0;
        n_out_code  = '0;
        if (r_vld) begin
            case (r_op)
                OP_KEY: begin
                    push_code = f_edge_code(key, r_pressed);
                    if ((held != r_pressed) && !fifo_stat.full) begin
                        fifo_ctl.push   = 1'b1;
                        n_key_held[key] = r_pressed;
                        n_accepted      = 1'b1;
                    end
                end
                OP_CTRL: begin
                    if (!fifo_stat.full) begin
                        fifo_ctl.push = 1'b1;
                        n_accepted    = 1'b1;
                    end
                end
                OP_CAPS: begin
                    // The code reports the LED state the press turns it to.
                    push_code = f_edge_code(r_caps_key, !r_led);
                    if (!fifo_stat.full) begin
                        fifo_ctl.push = 1'b1;
                        n_led         = !r_led;
                        n_accepted    = 1'b1;
                    end
                end
                OP_DEQ: begin
                    if (!fifo_stat.empty) begin
                        fifo_ctl.pop = 1'b1;
                        n_accepted   = 1'b1;
                        n_out_valid  = 1'b1;
                        n_out_code   = head_code;
                    end
                end
                OP_CLEAR: begin
                    fifo_ctl.clear = 1'b1;
                    n_key_held     = '0;
                    n_led          = 1'b0;
                    n_accepted     = 1'b1;
                end
                default: begin
                    // Unused operations leave everything as it is.
                end
            endcase
        end
    end

    kecq_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (fifo_ctl),
        .i_wdata     (push_code),
        .o_stat      (fifo_stat),
        .o_head_code (head_code),
        .o_count     (count),
        .o_next_count(next_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_held <= '0;
            r_led      <= 1'b0;
            r_caps_key <= CAPS_KEY_RESET;
            r_done     <= 1'b0;
        end else begin
            r_key_held <= n_key_held;
            r_led      <= n_led;
            r_done     <= r_vld;
            if (i_cfg_we) begin
                r_caps_key <= i_cfg_data;
            end
        end
        if (r_vld) begin
            r_accepted    <= n_accepted;
            r_out_valid   <= n_out_valid;
            r_out_code    <= n_out_code;
            r_serial_code <= n_out_valid ? f_serial(n_out_code) : '0;
            // The count is reported modulo 32 for deep queues.
            r_fill_count  <= FILL_BITS'(next_count);
        end
    end

    assign o_done        = r_done;
    assign o_accepted    = r_accepted;
    assign o_out_valid   = r_out_valid;
    assign o_out_code    = r_out_code;
    assign o_serial_code = r_serial_code;
    // The LED register commits on the same edge as the result register, so
    // during the strobe it shows the state after this command.
    assign o_caps_led    = r_led;
    assign o_fill_count  = r_fill_count;

    // Every transfer yields its result through the input and result registers.
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##2 o_done)
        else $error("command transfer without a result two cycles later");

    // A dequeue decoded on a non-empty queue must return a code.
    a_pop_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && (r_op == OP_DEQ) && (count != '0)) |=> (o_done && o_out_valid))
        else $error("dequeue on a non-empty queue returned no code");

    // The fill count never passes the queue depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= CW'(QUEUE_DEPTH))
        else $error("queue fill count above depth");

    // A returned code is always counted as a successful operation.
    a_valid_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_out_valid) |-> o_accepted)
        else $error("code returned without acceptance");

endmodule

### tb/sv/tb.sv
// Self-checking testbench for key_event_code_queue_unit: directed and random
// commands, with every result checked against a predictor held in the bench.
// Depends on kecq_pkg and on the RTL of key_event_code_queue_unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kecq_pkg::*;

    // The bench runs the block at its default depth.
    localparam int QDEPTH       = 16;
    // Idle cycles waited after the last result, enough to leave the pipeline
    // empty with some margin.
    localparam int DRAIN_CYCLES = 4;
    // Operation codes that the block ignores.
    localparam t_op OP_UNUSED_LO = 3'd5;
    localparam t_op OP_UNUSED_HI = 3'd7;

    // One result as the block reports it.
    typedef struct {
        logic  accepted;
        logic  out_valid;
        t_code out_code;
        t_code serial_code;
        logic  caps_led;
        t_fill fill_count;
    } t_kq_result;

    // Every input has a known value from time zero.
    logic  i_clk          = 1'b0;
    logic  i_rst_n        = 1'b0;
    logic  i_start        = 1'b0;
    t_op   i_op           = OP_KEY;
    t_code i_key_code     = '0;
    logic  i_pressed      = 1'b0;
    t_code i_control_code = '0;
    logic  i_cfg_we       = 1'b0;
    t_key  i_cfg_data     = '0;

    logic  o_busy;
    logic  o_done;
    logic  o_accepted;
    logic  o_out_valid;
    t_code o_out_code;
    t_code o_serial_code;
    logic  o_caps_led;
    t_fill o_fill_count;

    // Predictor state: the queued codes, the map of keys held down, the LED
    // and the caps lock key number last written.
    t_code              code_fifo[$];
    logic [KEY_COUNT-1:0] held_keys    = '0;
    logic               led_state    = 1'b0;
    t_key               caps_key_cfg = CAPS_KEY_RESET;

    // Results predicted for accepted commands, oldest first.
    t_kq_result pending_results[$];

    int sender_idle_pct = 18;
    int error_count     = 0;
    int checked_count   = 0;
    int full_rejects    = 0;
    int op_counts[8]    = '{default: 0};

    key_event_code_queue_unit #(
        .QUEUE_DEPTH(QDEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_op          (i_op),
        .i_key_code    (i_key_code),
        .i_pressed     (i_pressed),
        .i_control_code(i_control_code),
        .o_done        (o_done),
        .o_accepted    (o_accepted),
        .o_out_valid   (o_out_valid),
        .o_out_code    (o_out_code),
        .o_serial_code (o_serial_code),
        .o_caps_led    (o_caps_led),
        .o_fill_count  (o_fill_count),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data)
    );

    // 2 ns clock period, first rising edge at 1 ns.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Works out the result of one command and advances the predictor state.
    // An enqueue into a full queue changes nothing at all, so the key map and
    // the LED are only updated once the code has found room.
    function automatic t_kq_result predict_key_queue(input t_op op, input t_code key_code,
                                                     input logic pressed, input t_code ctrl);
        t_kq_result res;
        t_key       key;
        t_code      inv;
        logic       room;
        logic       led_after;
        res       = '{default: '0};
        key       = key_code[KEY_BITS-1:0];
        room      = code_fifo.size() < QDEPTH;
        led_after = ~led_state;
        case (op)
            OP_KEY: begin
                // A repeat of the key's present state is dropped.
                if (held_keys[key] != pressed && room) begin
                    code_fifo.push_back({~pressed, key});
                    held_keys[key] = pressed;
                    res.accepted   = 1'b1;
                end
            end
            OP_CTRL: begin
                if (room) begin
                    code_fifo.push_back(ctrl);
                    res.accepted = 1'b1;
                end
            end
            OP_CAPS: begin
                // The code is a press when the LED turns on, a release when off.
                if (room) begin
                    code_fifo.push_back({~led_after, caps_key_cfg});
                    led_state    = led_after;
                    res.accepted = 1'b1;
                end
            end
            OP_DEQ: begin
                if (code_fifo.size() != 0) begin
                    res.out_code    = code_fifo.pop_front();
                    inv             = ~res.out_code;
                    res.serial_code = {inv[CODE_BITS-2:0], inv[CODE_BITS-1]};
                    res.accepted    = 1'b1;
                    res.out_valid   = 1'b1;
                end
            end
            OP_CLEAR: begin
                code_fifo.delete();
                held_keys    = '0;
                led_state    = 1'b0;
                res.accepted = 1'b1;
            end
            default: begin
                // Unused codes leave the block untouched.
            end
        endcase
        res.caps_led   = led_state;
        res.fill_count = t_fill'(code_fifo.size());
        return res;
    endfunction

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Result checker. The receiver cannot hold results off, so every cycle
    // with o_done high is a transfer and is compared with the oldest
    // prediction.
    always @(posedge i_clk) begin : result_check
        t_kq_result want;
        if (i_rst_n) begin
            if ($isunknown(o_done)) begin
                $display("%0t ns: o_done mismatch, expected 0 or 1, actual %b", $time, o_done);
                error_count++;
            end else if (o_done) begin
                if (pending_results.size() == 0) begin
                    $display("%0t ns: result mismatch, expected no result, actual code %0h",
                             $time, o_out_code);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("accepted", want.accepted, o_accepted);
                    compare_field("out_valid", want.out_valid, o_out_valid);
                    compare_field("out_code", want.out_code, o_out_code);
                    compare_field("serial_code", want.serial_code, o_serial_code);
                    compare_field("caps_led", want.caps_led, o_caps_led);
                    compare_field("fill_count", want.fill_count, o_fill_count);
                    checked_count++;
                end
            end
        end
    end

    // Sends one command. Before it the sender may idle for a random number of
    // cycles, with start low and noise on the payload; the command is then
    // held until the rising edge at which busy is low, which is the transfer,
    // and only then is its result predicted.
    task automatic send_command(input t_op op, input t_code key_code,
                                input logic pressed, input t_code ctrl);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            @(negedge i_clk);
            i_start        <= 1'b0;
            i_op           <= t_op'($urandom_range(0, 7));
            i_key_code     <= t_code'($urandom_range(0, 255));
            i_pressed      <= 1'($urandom_range(0, 1));
            i_control_code <= t_code'($urandom_range(0, 255));
        end
        @(negedge i_clk);
        i_start        <= 1'b1;
        i_op           <= op;
        i_key_code     <= key_code;
        i_pressed      <= pressed;
        i_control_code <= ctrl;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        if (op inside {OP_KEY, OP_CTRL, OP_CAPS} && code_fifo.size() >= QDEPTH)
            full_rejects++;
        pending_results.push_back(predict_key_queue(op, key_code, pressed, ctrl));
        op_counts[op]++;
    endtask

    // Lowers start and waits until every predicted result has come back,
    // then lets the pipeline run empty.
    task automatic wait_queue_idle();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes the caps lock key number, only while nothing is in flight.
    task automatic write_caps_key(input t_key value);
        wait_queue_idle();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        caps_key_cfg = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Every operation but the clear, the key range at both ends, bit 7 of the key
    // ignored, repeated key states dropped, the caps lock toggle at the reset
    // key number, a dequeue from an empty queue and the unused codes.
    task automatic test_directed_ops();
        send_command(OP_DEQ, 8'h00, 1'b0, 8'h5A);
        send_command(OP_KEY, 8'h00, 1'b0, 8'hFF);
        send_command(OP_KEY, 8'h00, 1'b1, 8'h00);
        send_command(OP_KEY, 8'h00, 1'b1, 8'h00);
        send_command(OP_KEY, 8'hFF, 1'b1, 8'h00);
        send_command(OP_KEY, 8'h80, 1'b0, 8'h00);
        send_command(OP_CTRL, 8'hFF, 1'b1, 8'h00);
        send_command(OP_CTRL, 8'h00, 1'b0, 8'hFF);
        send_command(OP_CAPS, 8'h00, 1'b0, 8'h00);
        send_command(OP_CAPS, 8'hFF, 1'b1, 8'hFF);
        send_command(OP_UNUSED_HI, 8'h01, 1'b1, 8'h01);
        send_command(OP_UNUSED_LO, 8'h02, 1'b0, 8'h02);
        send_command(OP_DEQ, 8'hFF, 1'b1, 8'hFF);
    endtask

    // Fills the queue with the LED on and a key held, checks that every kind
    // of enqueue is turned away without side effects, then that a clear
    // releases the keys and turns the LED off.
    task automatic test_full_queue();
        send_command(OP_CAPS, 8'h00, 1'b0, 8'h00);
        while (code_fifo.size() < QDEPTH)
            send_command(OP_CTRL, 8'h00, 1'b0, t_code'($urandom_range(0, 255)));
        send_command(OP_KEY, 8'h05, 1'b1, 8'h00);
        send_command(OP_CTRL, 8'h00, 1'b0, 8'hA5);
        send_command(OP_CAPS, 8'h00, 1'b0, 8'h00);
        send_command(OP_DEQ, 8'h00, 1'b0, 8'h00);
        send_command(OP_CLEAR, 8'h00, 1'b0, 8'h00);
        send_command(OP_KEY, 8'h7F, 1'b0, 8'h00);
        send_command(OP_CAPS, 8'h00, 1'b0, 8'h00);
    endtask

    // Random traffic. The phase alternates between filling, where enqueues
    // outweigh dequeues, and draining, so the queue runs between empty and
    // full many times. Half the key events use a pool of eight keys, which
    // gives many repeats and toggles; the rest use any key code.
    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input t_key caps_key);
        int    phase_left;
        logic  filling;
        int    roll;
        t_op   op;
        t_code key_code;
        write_caps_key(caps_key);
        sender_idle_pct = idle_pct;
        filling         = 1'b1;
        phase_left      = $urandom_range(20, 60);
        repeat (count) begin
            if (phase_left == 0) begin
                filling    = ~filling;
                phase_left = $urandom_range(20, 60);
            end
            phase_left--;
            roll = $urandom_range(0, 99);
            if (filling) begin
                if (roll < 40)      op = OP_KEY;
                else if (roll < 64) op = OP_CTRL;
                else if (roll < 74) op = OP_CAPS;
                else if (roll < 94) op = OP_DEQ;
                else if (roll < 95) op = OP_CLEAR;
                else                op = t_op'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            end else begin
                if (roll < 15)      op = OP_KEY;
                else if (roll < 25) op = OP_CTRL;
                else if (roll < 30) op = OP_CAPS;
                else if (roll < 94) op = OP_DEQ;
                else if (roll < 95) op = OP_CLEAR;
                else                op = t_op'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            end
            if ($urandom_range(0, 1))
                key_code = {1'($urandom_range(0, 1)), 4'b0000, 3'($urandom_range(0, 7))};
            else
                key_code = t_code'($urandom_range(0, 255));
            send_command(op, key_code, 1'($urandom_range(0, 1)),
                         t_code'($urandom_range(0, 255)));
        end
    endtask

    // Main sequence: reset once, the directed tests at the reset caps lock
    // key number, then three random phases, first with light sender gaps,
    // then heavy gaps, then none, each at a different caps lock key number.
    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_ops();
        test_full_queue();
        test_random_traffic(250, 18, t_key'($urandom_range(1, 126)));
        test_random_traffic(250, 77, t_key'(0));
        test_random_traffic(250, 0, t_key'(KEY_COUNT - 1));
        wait_queue_idle();

        $display("Ran %0d key events, %0d control codes, %0d caps presses, %0d dequeues,",
                 op_counts[OP_KEY], op_counts[OP_CTRL], op_counts[OP_CAPS],
                 op_counts[OP_DEQ]);
        $display("%0d clears and %0d unused codes; %0d results checked, %0d full-queue rejects.",
                 op_counts[OP_CLEAR], op_counts[5] + op_counts[6] + op_counts[7],
                 checked_count, full_rejects);
        if (error_count == 0)
            $display("key_event_code_queue_unit test passed");
        else
            $display("key_event_code_queue_unit test failed");
        $finish;
    end

    // Watchdog: ends a run that hangs.
    initial begin
        #200000;
        $display("Timed out with %0d results outstanding.", pending_results.size());
        $display("key_event_code_queue_unit test failed");
        $finish;
    end

endmodule

### filelist.f
rtl/kecq_pkg.sv
rtl/kecq_ram.sv
rtl/kecq_fifo.sv
rtl/key_event_code_queue_unit.sv
tb/sv/tb.sv
